/* rtl/segmented_level_meter_unit_defines.svh */
// assertion macros for the level meter rtl
// no dependencies
`ifndef SEGMENTED_LEVEL_METER_UNIT_DEFINES_SVH
`define SEGMENTED_LEVEL_METER_UNIT_DEFINES_SVH

// same-cycle implication
`define SLMU_ASSERT_NOW(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLMU_ASSERT_NEXT(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slmu_pkg.sv */
// types, constants and the log2 fraction table of the level meter
// no dependencies
package slmu_pkg;

  localparam int MAX_SEGMENTS_DEF       = 16;
  localparam int MAX_BUFFER_SAMPLES_DEF = 65536;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 48;
  localparam int DB_W     = 12;
  localparam int NSEG_W   = 5;
  localparam int HOLD_W   = 27;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam int DIFF_W   = 16;
  localparam int P_W      = 34;
  localparam int LVL_W    = 16;
  localparam int DB_COEF_Q10 = 49321;
  localparam int LEVEL_MIN   = -4096;
  localparam int LOG_OFFSET  = 30 * 256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [TIME_W-1:0]          time_t;
  typedef logic signed [DB_W-1:0]     db_t;
  typedef logic [NSEG_W-1:0]          nseg_t;
  typedef logic [HOLD_W-1:0]          hold_t;

  typedef enum logic [STAT_W-1:0] {
    ST_BLANK  = 2'd0,
    ST_SIGNAL = 2'd1,
    ST_HIGH   = 2'd2,
    ST_CLIP   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGNAL_FLOOR = 3'd0,
    REG_HIGH_LEVEL   = 3'd1,
    REG_CLIP_LEVEL   = 3'd2,
    REG_SEG_COUNT    = 3'd3,
    REG_CLIP_HOLD    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic acc;
    logic close;
    logic norm;
    logic logc;
    logic lvl;
    logic scale;
    logic seg;
  } slmu_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic seg_last;
    logic out_free;
  } slmu_sts_t;

  function automatic logic [8:0] slmu_frac_tab(input logic [4:0] k);
    logic [8:0] v;
    case (k)
      5'd0:  v = 9'd0;
      5'd1:  v = 9'd22;
      5'd2:  v = 9'd44;
      5'd3:  v = 9'd63;
      5'd4:  v = 9'd82;
      5'd5:  v = 9'd100;
      5'd6:  v = 9'd118;
      5'd7:  v = 9'd134;
      5'd8:  v = 9'd150;
      5'd9:  v = 9'd165;
      5'd10: v = 9'd179;
      5'd11: v = 9'd193;
      5'd12: v = 9'd207;
      5'd13: v = 9'd220;
      5'd14: v = 9'd232;
      5'd15: v = 9'd244;
      5'd16: v = 9'd256;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // interpolated log2 fraction in q8 from the 8 bits under the leading one
  function automatic logic [8:0] slmu_frac(input logic [7:0] m);
    logic [8:0] t0;
    logic [8:0] t1;
    logic [9:0] prod;
    t0 = slmu_frac_tab({1'b0, m[7:4]});
    t1 = slmu_frac_tab({1'b0, m[7:4]} + 5'd1);
    prod = 10'((t1 - t0) * m[3:0]) + 10'd8;
    return t0 + 9'(prod >> 4);
  endfunction

endpackage

/* rtl/slmu_ifs.sv */
// valid/ready channel interfaces for samples in and segments out
// depends on slmu_pkg
interface slmu_in_if;
  import slmu_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    buffer_end;
  time_t   time_us;
  modport source (output valid, output sample, output buffer_end, output time_us,
                  input ready);
  modport sink (input valid, input sample, input buffer_end, input time_us,
                output ready);
endinterface

interface slmu_out_if;
  import slmu_pkg::*;
  logic        valid;
  logic        ready;
  nseg_t       segment_number;
  logic [1:0]  status;
  logic        last_segment;
  modport source (output valid, output segment_number, output status,
                  output last_segment, input ready);
  modport sink (input valid, input segment_number, input status,
                input last_segment, output ready);
endinterface

/* rtl/slmu_dp.sv */
// datapath: energy accumulate, normalize, log level, segment compare, output register
// depends on slmu_pkg and the assertion header
`include "segmented_level_meter_unit_defines.svh"
module slmu_dp #(
  parameter int MAX_SEGMENTS       = slmu_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_BUFFER_SAMPLES = slmu_pkg::MAX_BUFFER_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  slmu_pkg::slmu_cmd_t         cmd,
  output slmu_pkg::slmu_sts_t         sts,
  input  slmu_pkg::sample_t           sample,
  input  slmu_pkg::time_t             time_us,
  input  logic                        cfg_we,
  input  logic [slmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slmu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output slmu_pkg::nseg_t             out_segment,
  output logic [1:0]                  out_status,
  output logic                        out_last
);
  import slmu_pkg::*;

  localparam int EW    = 31 + $clog2(MAX_BUFFER_SAMPLES);
  localparam int CW    = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam int CNW   = CW + 8;
  localparam int SHS_W = $clog2(EW);
  localparam int SHC_W = $clog2(CNW);
  localparam int SEGW  = $clog2(MAX_SEGMENTS + 1);
  localparam int PW    = LVL_W + SEGW + 1;

  db_t   floor_db, high_db, clip_db;
  nseg_t seg_cfg;
  hold_t hold_us;

  logic [EW-1:0]    esum;
  logic [CW-1:0]    cnt;
  logic [EW-1:0]    nsum;
  logic [CNW-1:0]   ncnt;
  logic [SHS_W-1:0] sh_s;
  logic [SHC_W-1:0] sh_c;
  time_t            now;
  time_t            hold_until;
  logic             zero_sum;
  logic signed [P_W-1:0]   p;
  logic signed [LVL_W-1:0] lvl;
  logic signed [PW-1:0]    l_n, h_n, c_n, top, bot, floor_ext;
  logic [SEGW-1:0]         nseg, idx;

  logic signed [2*SAMPLE_W-1:0] sq;
  logic [EW-1:0]   esum_next;
  logic [CW-1:0]   cnt_next;
  logic            room;
  logic [SEGW-1:0] nseg_sat;
  logic [8:0]      ts, tc;
  logic signed [DIFF_W-1:0] ds, dc, d;
  logic signed [P_W-1:0]    p_next;
  logic sig_on, high_on, clip_on, is_clip;
  logic signed [PW-1:0] high_t, clip_t;
  status_t  stat;
  logic [TIME_W:0] dl;
  logic      nsum_done, ncnt_done;

  assign sq        = sample * sample;
  assign room      = cnt < CW'(MAX_BUFFER_SAMPLES);
  assign esum_next = room ? esum + EW'(sq[30:0]) : esum;
  assign cnt_next  = room ? cnt + CW'(1) : cnt;

  assign nsum_done = (nsum == '0) || nsum[EW-1];
  assign ncnt_done = ncnt[CNW-1];

  assign ts = slmu_frac(nsum[EW-2 -: 8]);
  assign tc = slmu_frac(ncnt[CNW-2 -: 8]);
  assign ds = DIFF_W'((EW - 1 - int'(sh_s)) * 256 + int'(ts));
  assign dc = DIFF_W'((CNW - 1 - int'(sh_c)) * 256 + int'(tc));
  assign d  = ds - dc - DIFF_W'(LOG_OFFSET);
  assign p_next = P_W'(d) * P_W'(DB_COEF_Q10) + P_W'(131072);

  always_comb begin
    if (seg_cfg == '0) begin
      nseg_sat = SEGW'(1);
    end else if (int'(seg_cfg) > MAX_SEGMENTS) begin
      nseg_sat = SEGW'(MAX_SEGMENTS);
    end else begin
      nseg_sat = SEGW'(seg_cfg);
    end
  end

  assign floor_ext = PW'(floor_db);
  assign sig_on  = !(bot > h_n);
  assign high_on = !(top < h_n);
  assign high_t  = (bot > h_n) ? bot : h_n;
  assign clip_on = !(top < c_n);
  assign clip_t  = (bot > c_n) ? bot : c_n;
  assign is_clip = clip_on && ((l_n > clip_t) || (hold_until > now));
  assign dl      = {1'b0, now} + (TIME_W+1)'(hold_us);

  always_comb begin
    if (is_clip) begin
      stat = ST_CLIP;
    end else if (high_on && (l_n > high_t)) begin
      stat = ST_HIGH;
    end else if (sig_on && (l_n > bot)) begin
      stat = ST_SIGNAL;
    end else begin
      stat = ST_BLANK;
    end
  end

  assign sts.norm_done = nsum_done && ncnt_done;
  assign sts.seg_last  = (idx == nseg - SEGW'(1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_db   <= -12'sd960;
      high_db    <= -12'sd192;
      clip_db    <= -12'sd48;
      seg_cfg    <= 5'd16;
      hold_us    <= 27'd1000000;
      esum       <= '0;
      cnt        <= '0;
      hold_until <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIGNAL_FLOOR: floor_db <= cfg_data[DB_W-1:0];
          REG_HIGH_LEVEL:   high_db  <= cfg_data[DB_W-1:0];
          REG_CLIP_LEVEL:   clip_db  <= cfg_data[DB_W-1:0];
          REG_SEG_COUNT:    seg_cfg  <= cfg_data[NSEG_W-1:0];
          REG_CLIP_HOLD:    hold_us  <= cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.acc) begin
        if (cmd.close) begin
          esum <= '0;
          cnt  <= '0;
          nsum <= esum_next;
          ncnt <= CNW'(cnt_next);
          sh_s <= '0;
          sh_c <= '0;
          now  <= time_us;
        end else begin
          esum <= esum_next;
          cnt  <= cnt_next;
        end
      end
      if (cmd.norm) begin
        if (!nsum_done) begin
          nsum <= nsum << 1;
          sh_s <= sh_s + SHS_W'(1);
        end
        if (!ncnt_done) begin
          ncnt <= ncnt << 1;
          sh_c <= sh_c + SHC_W'(1);
        end
      end
      if (cmd.logc) begin
        p        <= p_next;
        zero_sum <= (nsum == '0);
      end
      if (cmd.lvl) begin
        lvl <= zero_sum ? LVL_W'(LEVEL_MIN) : p[P_W-1 -: LVL_W];
      end
      if (cmd.scale) begin
        l_n  <= PW'(lvl) * PW'({1'b0, nseg_sat});
        h_n  <= PW'(high_db) * PW'({1'b0, nseg_sat});
        c_n  <= PW'(clip_db) * PW'({1'b0, nseg_sat});
        nseg <= nseg_sat;
        idx  <= '0;
        top  <= '0;
        bot  <= floor_ext;
      end
      if (out_valid && out_ready && !cmd.seg) begin
        out_valid <= 1'b0;
      end
      if (cmd.seg) begin
        out_valid   <= 1'b1;
        out_segment <= NSEG_W'(nseg - idx);
        out_status  <= stat;
        out_last    <= sts.seg_last;
        top <= bot;
        bot <= bot + floor_ext;
        idx <= idx + SEGW'(1);
        if (is_clip && (hold_until < now)) begin
          hold_until <= dl[TIME_W] ? {TIME_W{1'b1}} : dl[TIME_W-1:0];
        end
      end
    end
  end

  `SLMU_ASSERT_NEXT(a_seg_shows, clk, rst, cmd.seg, out_valid, "segment result not presented")
  `SLMU_ASSERT_NOW(a_seg_room, clk, rst, cmd.seg, (!out_valid || out_ready), "result overwritten")
  `SLMU_ASSERT_NOW(a_cnt_cap, clk, rst, 1'b1, (cnt <= CW'(MAX_BUFFER_SAMPLES)), "count past cap")

endmodule

/* rtl/slmu_ctrl.sv */
// controller: sequences accumulate, normalize, log, level, scale and segment walk
// depends on slmu_pkg
module slmu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output slmu_pkg::slmu_cmd_t cmd,
  input  slmu_pkg::slmu_sts_t sts
);
  import slmu_pkg::*;

  typedef enum logic [2:0] {
    S_ACC, S_NORM, S_LOG, S_LVL, S_SCALE, S_SEG
  } state_t;

  state_t state;

  assign in_ready  = (state == S_ACC);
  assign cmd.acc   = in_ready && in_valid;
  assign cmd.close = cmd.acc && in_last;
  assign cmd.norm  = (state == S_NORM);
  assign cmd.logc  = (state == S_LOG);
  assign cmd.lvl   = (state == S_LVL);
  assign cmd.scale = (state == S_SCALE);
  assign cmd.seg   = (state == S_SEG) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      unique case (state)
        S_ACC:   if (cmd.close) state <= S_NORM;
        S_NORM:  if (sts.norm_done) state <= S_LOG;
        S_LOG:   state <= S_LVL;
        S_LVL:   state <= S_SCALE;
        S_SCALE: state <= S_SEG;
        S_SEG:   if (cmd.seg && sts.seg_last) state <= S_ACC;
        default: state <= S_ACC;
      endcase
    end
  end

endmodule

/* rtl/segmented_level_meter_unit.sv */
// rms level meter driving a segment bargraph: one beat per sample in, one per segment out
// after a buffer_end beat the controller runs the normalize state (leading-one search over
// energy and count), then the log, level and scale states, before the first segment
// throughput: one sample per cycle while accumulating; segments one per cycle while the output is free
// reset: synchronous, clears energy, count, clip deadline, output valid and loads register defaults
module segmented_level_meter_unit #(
  parameter int MAX_SEGMENTS       = slmu_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_BUFFER_SAMPLES = slmu_pkg::MAX_BUFFER_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  slmu_in_if.sink                         samples,
  slmu_out_if.source                      segments,
  input  logic                            cfg_we,
  input  logic [slmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slmu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slmu_pkg::*;

  slmu_cmd_t cmd;
  slmu_sts_t sts;

  slmu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_last  (samples.buffer_end),
    .in_ready (samples.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  slmu_dp #(
    .MAX_SEGMENTS       (MAX_SEGMENTS),
    .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .sample      (samples.sample),
    .time_us     (samples.time_us),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (segments.valid),
    .out_ready   (segments.ready),
    .out_segment (segments.segment_number),
    .out_status  (segments.status),
    .out_last    (segments.last_segment)
  );

endmodule

/* tb/tb.sv */
// self-checking testbench for segmented_level_meter_unit: directed and random sample buffers in,
// predicted bargraph segments compared beat by beat with the dut output
// depends on slmu_pkg, slmu_ifs and segmented_level_meter_unit from the rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slmu_pkg::*;

  typedef struct {
    sample_t    sample;
    logic       buffer_end;
    time_t      time_us;
  } sample_beat_t;

  typedef struct {
    nseg_t   segment_number;
    status_t status;
    logic    last_segment;
  } segment_beat_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int TB_BUFFER_CAP  = 16;
  localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int LOG2_LUT [17] = '{0, 22, 44, 63, 82, 100, 118, 134, 150,
                                   165, 179, 193, 207, 220, 232, 244, 256};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slmu_in_if  samples_if ();
  slmu_out_if segments_if ();

  segmented_level_meter_unit #(
    .MAX_SEGMENTS       (MAX_SEGMENTS_DEF),
    .MAX_BUFFER_SAMPLES (TB_BUFFER_CAP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if.sink),
    .segments  (segments_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // meter model state
  longint floor_db, high_db, clip_db;
  int unsigned seg_count;
  longint unsigned hold_us, energy_acc, hold_deadline;
  int unsigned sample_total;

  sample_beat_t  pending_samples[$];
  segment_beat_t expected_segments[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;
  int stalled_cycles;
  bit in_fire;
  longint unsigned now_us;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint log2_q8(longint unsigned x);
    int msb;
    int m, k, j;
    longint unsigned y;
    msb = 0;
    y = x;
    while (y > 1) begin
      y = y >> 1;
      msb++;
    end
    if (msb >= 8) m = int'((x >> (msb - 8)) & 64'hFF);
    else m = int'((x << (8 - msb)) & 64'hFF);
    k = m >> 4;
    j = m & 15;
    return longint'(msb) * 256 + LOG2_LUT[k] + (((LOG2_LUT[k+1] - LOG2_LUT[k]) * j + 8) >> 4);
  endfunction

  function automatic longint level_sixteenth_db();
    longint d;
    longint p;
    if (energy_acc == 0 || sample_total == 0) return LEVEL_MIN;
    d = log2_q8(energy_acc) - log2_q8(longint'(sample_total)) - LOG_OFFSET;
    p = d * DB_COEF_Q10 + 131072;
    return p >>> 18;
  endfunction

  task automatic predict_segments(longint unsigned now);
    longint lvl, n, l, h, c, top, bot, high_t, clip_t;
    int unsigned nseg;
    bit sig_on, high_on, clip_on;
    segment_beat_t seg;
    longint unsigned dl;
    lvl = level_sixteenth_db();
    energy_acc = 0;
    sample_total = 0;
    nseg = seg_count;
    if (nseg == 0) nseg = 1;
    if (nseg > MAX_SEGMENTS_DEF) nseg = MAX_SEGMENTS_DEF;
    n = longint'(nseg);
    l = lvl * n;
    h = high_db * n;
    c = clip_db * n;
    for (int unsigned i = 0; i < nseg; i++) begin
      top = floor_db * longint'(i);
      bot = floor_db * longint'(i + 1);
      sig_on = !(bot > h);
      high_on = !(top < h);
      high_t = bot > h ? bot : h;
      clip_on = !(top < c);
      clip_t = bot > c ? bot : c;
      seg.status = ST_BLANK;
      if (clip_on && (l > clip_t || hold_deadline > now)) begin
        seg.status = ST_CLIP;
        if (hold_deadline < now) begin
          dl = now + hold_us;
          hold_deadline = dl > TIME_MAX ? TIME_MAX : dl;
        end
      end else if (high_on && l > high_t) begin
        seg.status = ST_HIGH;
      end else if (sig_on && l > bot) begin
        seg.status = ST_SIGNAL;
      end
      seg.segment_number = nseg_t'(nseg - i);
      seg.last_segment = (i + 1 == nseg);
      expected_segments.insert(expected_segments.size(), seg);
    end
  endtask

  // input side: accept at rising edge, drive at falling edge
  always @(posedge clk) begin
    longint s;
    in_fire = samples_if.valid && samples_if.ready && !rst;
    if (in_fire) begin
      s = longint'(samples_if.sample);
      if (sample_total < TB_BUFFER_CAP) begin
        energy_acc += longint'(s * s);
        sample_total++;
      end
      if (samples_if.buffer_end) predict_segments(samples_if.time_us);
    end
  end

  always @(negedge clk) begin
    sample_beat_t b;
    if (!rst && (!samples_if.valid || in_fire)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_samples.pop_front();
        samples_if.valid <= 1'b1;
        samples_if.sample <= b.sample;
        samples_if.buffer_end <= b.buffer_end;
        samples_if.time_us <= b.time_us;
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
    segments_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output side: compare every segment beat with the oldest prediction; watchdog on stalls
  always @(posedge clk) begin
    segment_beat_t want;
    bit out_fire;
    bit take_fire;
    out_fire = segments_if.valid && segments_if.ready && !rst;
    take_fire = samples_if.valid && samples_if.ready && !rst;
    if (out_fire) begin
      if (expected_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected segment beat: seg %0d status %0d last %0b",
                   segments_if.segment_number, segments_if.status,
                   segments_if.last_segment);
      end else begin
        want = expected_segments.pop_front();
        if (segments_if.segment_number !== want.segment_number ||
            segments_if.status !== want.status ||
            segments_if.last_segment !== want.last_segment) begin
          mismatches++;
          if (mismatches <= 10)
            $display("segment mismatch: exp seg %0d status %0d last %0b, got seg %0d status %0d last %0b",
                     want.segment_number, want.status, want.last_segment,
                     segments_if.segment_number, segments_if.status,
                     segments_if.last_segment);
        end
      end
    end
    if (rst || take_fire || out_fire) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SIGNAL_FLOOR: floor_db = longint'($signed(val[DB_W-1:0]));
      REG_HIGH_LEVEL:   high_db = longint'($signed(val[DB_W-1:0]));
      REG_CLIP_LEVEL:   clip_db = longint'($signed(val[DB_W-1:0]));
      REG_SEG_COUNT:    seg_count = int'(val[NSEG_W-1:0]);
      REG_CLIP_HOLD:    hold_us = longint'(val[HOLD_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_meter(logic [11:0] fl, logic [11:0] hi, logic [11:0] cl,
                            logic [4:0] ns, logic [26:0] hold);
    write_reg(REG_SIGNAL_FLOOR, 27'(fl));
    write_reg(REG_HIGH_LEVEL, 27'(hi));
    write_reg(REG_CLIP_LEVEL, 27'(cl));
    write_reg(REG_SEG_COUNT, 27'(ns));
    write_reg(REG_CLIP_HOLD, hold);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || samples_if.valid || expected_segments.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t pick_sample(int kind);
    case (kind)
      0: return sample_t'($urandom);
      1: return $urandom_range(1) ? sample_t'(-32768) : sample_t'(32767);
      2: return sample_t'(0);
      default: return sample_t'($signed($urandom_range(255)) - 128);
    endcase
  endfunction

  task automatic push_buffer(int len, int kind, longint unsigned t);
    sample_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.sample = pick_sample(kind);
      b.buffer_end = (i == len - 1);
      b.time_us = (i == len - 1) ? time_t'(t) : time_t'({$urandom, $urandom});
      pending_samples.insert(pending_samples.size(), b);
    end
  endtask

  task automatic push_random_buffers(int beats);
    int len;
    int got;
    got = 0;
    while (got < beats) begin
      len = $urandom_range(9) == 0 ? $urandom_range(40, 10) : $urandom_range(6, 1);
      case ($urandom_range(9))
        0: now_us = {$urandom, $urandom};
        1: now_us = now_us;
        default: now_us = now_us + $urandom_range(3000000);
      endcase
      now_us &= TIME_MAX;
      push_buffer(len, $urandom_range(3), now_us);
      got += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.buffer_end = 1'b0;
    samples_if.time_us = '0;
    segments_if.ready = 1'b0;
    floor_db = -960;
    high_db = -192;
    clip_db = -48;
    seg_count = 16;
    hold_us = 1000000;
    energy_acc = 0;
    sample_total = 0;
    hold_deadline = 0;
    mismatches = 0;
    stalled_cycles = 0;
    now_us = 1000;
    send_idle_pct = 32;
    recv_idle_pct = 88;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: full scale, silence, single beats, clip hold and release
    push_buffer(1, 1, 10);
    push_buffer(1, 2, 20);
    push_buffer(3, 2, 30);
    push_buffer(2, 3, 500000);
    push_buffer(1, 1, 2000000);
    push_buffer(4, 0, 2000001);
    push_buffer(1, 1, 5000000);
    push_buffer(2, 2, 5000000);
    push_buffer(1, 0, 64'hFFFF_FFFF_FFF0);
    wait_idle();
    load_meter(-12'sd1600, 12'd0, 12'd0, 5'd1, 27'd0);
    push_buffer(1, 1, 100);
    push_buffer(2, 3, 200);
    push_random_buffers(10);
    wait_idle();
    load_meter(-12'sd1, -12'sd1600, -12'sd1600, 5'd0, 27'd100000000);
    now_us = 64'hFFFF_FFFF_F000;
    push_buffer(1, 1, now_us);
    push_buffer(1, 1, TIME_MAX);
    push_random_buffers(5);
    wait_idle();
    load_meter(12'h7FF, 12'h800, 12'h7FF, 5'd31, 27'h7FF_FFFF);
    now_us = 0;
    push_random_buffers(5);
    wait_idle();

    send_idle_pct = 88;
    recv_idle_pct = 32;
    load_meter(-12'sd480, -12'sd300, -12'sd100, 5'd7, 27'd1500000);
    push_random_buffers(10);
    wait_idle();
    load_meter(12'($urandom), 12'($urandom), 12'($urandom), 5'($urandom), 27'($urandom));
    push_random_buffers(10);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_meter(-12'sd960, -12'sd192, -12'sd48, 5'd16, 27'd1000000);
    // longer than the sample limit: the tail is neither summed nor counted
    push_buffer(TB_BUFFER_CAP + 3, 0, now_us + 10);
    push_random_buffers(10);
    wait_idle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/slmu_pkg.sv
rtl/slmu_ifs.sv
rtl/slmu_dp.sv
rtl/slmu_ctrl.sv
rtl/segmented_level_meter_unit.sv
tb/tb.sv
